// File: hdl/signed_decimal_formatter_unit_defines.svh
// Assertion helpers for the formatter RTL.
`ifndef SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH
`define SIGNED_DECIMAL_FORMATTER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define SDF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SDF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sdf_pkg.sv
package sdf_pkg;

  localparam int MAG_W  = 64;
  localparam int CAP_W  = 8;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 5;
  localparam int QDEPTH = 2;

  localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic signed [MAG_W-1:0] value;
    logic [CAP_W-1:0]        capacity;
  } sdf_cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_byte;
    logic              byte_written;
    logic [LEN_W-1:0]  length;
    logic              last;
  } sdf_txt_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             negative;
    logic [CAP_W-1:0] capacity;
  } sdf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sdf_qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_TRIM,
    BK_EMIT
  } sdf_back_state_t;

  typedef enum logic [1:0] {
    EK_TEXT,
    EK_EMPTY,
    EK_OVERFLOW
  } sdf_emit_kind_t;

endpackage

// File: hdl/sdf_front.sv
module sdf_front (
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  sdf_pkg::sdf_cmd_t cmd,
  input  sdf_pkg::sdf_qstat_t qstat,
  output logic             push,
  output sdf_pkg::sdf_item_t item
);
  import sdf_pkg::*;

  logic [MAG_W-1:0] raw;
  logic             neg;

  assign raw = cmd.value;
  assign neg = raw[MAG_W-1];

  // unsigned magnitude; most negative value comes out as 2^63
  assign item.mag      = neg ? (~raw + MAG_W'(1)) : raw;
  assign item.negative = neg;
  assign item.capacity = cmd.capacity;

  assign cmd_stall = qstat.full;
  assign push      = cmd_valid && !qstat.full;

endmodule

// File: hdl/sdf_queue.sv
module sdf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sdf_pkg::sdf_item_t  item,
  input  logic                pop,
  output sdf_pkg::sdf_item_t  head,
  output sdf_pkg::sdf_qstat_t qstat
);
  import sdf_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  sdf_item_t        mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign qstat.full  = (count == (PTR_W+1)'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

endmodule

// File: hdl/sdf_back.sv
`include "signed_decimal_formatter_unit_defines.svh"

module sdf_back #(
  parameter int DIGIT_LIMIT = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  sdf_pkg::sdf_qstat_t qstat,
  input  sdf_pkg::sdf_item_t  head,
  output logic                pop,
  output logic                txt_valid,
  input  logic                txt_stall,
  output sdf_pkg::sdf_txt_t   txt
);
  import sdf_pkg::*;

  localparam int BCD_W = 4 * DIGIT_LIMIT;
  localparam int BIT_W = $clog2(MAG_W);

  sdf_back_state_t  state, state_next;
  sdf_emit_kind_t   kind;
  logic [MAG_W-1:0] sh;
  logic [BCD_W-1:0] bcd;
  logic [BCD_W-1:0] adj;
  logic [BIT_W-1:0] bitcnt;
  logic             neg;
  logic [CAP_W-1:0] cap;
  logic [LEN_W-1:0] ndig;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] pos;

  logic [3:0]       top_digit;
  logic             trim_more;
  logic [LEN_W-1:0] txt_len;
  logic             fits;
  logic             load;
  logic             emit_last;
  logic             emit_digit;
  sdf_txt_t         emit_data;

  // shift-add-3 adjust, one per BCD digit
  always_comb begin
    adj = bcd;
    for (int d = 0; d < DIGIT_LIMIT; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
  end

  assign top_digit = bcd[BCD_W-1 -: 4];
  assign trim_more = (top_digit == 4'd0) && (ndig != LEN_W'(1));
  assign txt_len   = ndig + LEN_W'(neg);
  assign fits      = (CAP_W'(txt_len) + CAP_W'(1)) <= cap;

  always_comb begin
    emit_data  = '0;
    emit_last  = 1'b1;
    emit_digit = 1'b0;
    unique case (kind)
      EK_EMPTY: begin
        emit_data.text_byte    = ASCII_NUL;
        emit_data.byte_written = 1'b0;
        emit_data.length       = '0;
        emit_data.last         = 1'b1;
      end
      EK_OVERFLOW: begin
        emit_data.text_byte    = ASCII_NUL;
        emit_data.byte_written = 1'b1;
        emit_data.length       = '0;
        emit_data.last         = 1'b1;
      end
      default: begin
        emit_last              = (pos == len);
        emit_digit             = !emit_last && !(neg && pos == '0);
        emit_data.byte_written = 1'b1;
        emit_data.length       = len;
        emit_data.last         = emit_last;
        priority if (emit_last) begin
          emit_data.text_byte = ASCII_NUL;
        end else if (neg && pos == '0) begin
          emit_data.text_byte = ASCII_MINUS;
        end else begin
          emit_data.text_byte = ASCII_ZERO | {4'b0000, top_digit};
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          state_next = (head.capacity == '0) ? BK_EMIT : BK_CONV;
        end
      end
      BK_CONV: begin
        if (bitcnt == BIT_W'(MAG_W-1)) begin
          state_next = BK_TRIM;
        end
      end
      BK_TRIM: begin
        if (!trim_more) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load && emit_last) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop  = (state == BK_IDLE) && !qstat.empty;
    load = (state == BK_EMIT) && (!txt_valid || !txt_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      txt_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        txt_valid <= 1'b1;
      end else if (!txt_stall) begin
        txt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      txt <= emit_data;
    end
    unique case (state)
      BK_IDLE: begin
        if (pop) begin
          sh     <= head.mag;
          bcd    <= '0;
          bitcnt <= '0;
          neg    <= head.negative;
          cap    <= head.capacity;
          ndig   <= LEN_W'(DIGIT_LIMIT);
          len    <= '0;
          pos    <= '0;
          kind   <= (head.capacity == '0) ? EK_EMPTY : EK_TEXT;
        end
      end
      BK_CONV: begin
        bcd    <= {adj[BCD_W-2:0], sh[MAG_W-1]};
        sh     <= {sh[MAG_W-2:0], 1'b0};
        bitcnt <= bitcnt + BIT_W'(1);
      end
      BK_TRIM: begin
        if (trim_more) begin
          bcd  <= {bcd[BCD_W-5:0], 4'b0000};
          ndig <= ndig - LEN_W'(1);
        end else begin
          len  <= fits ? txt_len : '0;
          kind <= fits ? EK_TEXT : EK_OVERFLOW;
        end
      end
      BK_EMIT: begin
        if (load) begin
          pos <= pos + LEN_W'(1);
          if (emit_digit) begin
            bcd <= {bcd[BCD_W-5:0], 4'b0000};
          end
        end
      end
      default: ;
    endcase
  end

  `SDF_ASSERT(a_last_is_nul, clk, rst, txt_valid && txt.last |-> txt.text_byte == ASCII_NUL, "final byte is not the terminator")
  `SDF_ASSERT(a_unwritten_single, clk, rst, txt_valid && !txt.byte_written |-> txt.length == '0 && txt.last, "unwritten result not a lone final one")
  `SDF_ASSERT(a_body_printable, clk, rst, txt_valid && !txt.last |-> txt.text_byte != ASCII_NUL && txt.length != '0, "text body byte is empty")
  `SDF_ASSERT(a_conv_runs, clk, rst, state == BK_CONV && bitcnt != BIT_W'(MAG_W-1) |=> state == BK_CONV, "conversion left early")
  `SDF_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !txt_valid, "result valid after reset")

endmodule

// File: hdl/signed_decimal_formatter_unit.sv
// Signed 64-bit to decimal ASCII formatter. Each request (value, capacity) yields
// the text most significant character first, a '-' ahead of negatives and a zero
// terminator with last set; zero capacity gives one unwritten result, and text that
// does not fit gives a lone terminator with length 0. A request is dequeued, runs
// the binary-to-BCD shift-add-3 loop, one bit per cycle, then strips leading zeros
// and emits its result bytes while the sink does not stall. A zero-capacity
// request skips conversion and emits its single unwritten result directly. A
// two-entry queue takes new requests while the back end converts and emits.
module signed_decimal_formatter_unit #(
  parameter int DIGIT_LIMIT = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  sdf_pkg::sdf_cmd_t cmd,
  output logic              txt_valid,
  input  logic              txt_stall,
  output sdf_pkg::sdf_txt_t txt
);
  import sdf_pkg::*;

  sdf_qstat_t qstat;
  sdf_item_t  item;
  sdf_item_t  head;
  logic       push;
  logic       pop;

  sdf_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .qstat     (qstat),
    .push      (push),
    .item      (item)
  );

  sdf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  sdf_back #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt       (txt)
  );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sdf_pkg::*;

  localparam int DIGIT_LIMIT    = 20;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  sdf_cmd_t cmd       = '0;
  logic     txt_valid;
  logic     txt_stall = 1'b0;
  sdf_txt_t txt;

  sdf_cmd_t   pending_requests [$];
  sdf_txt_t   expected_text [$];
  sdf_txt_t   want;
  logic [7:0] rendered_text [0:21];

  int send_idle_pct       = 31;
  int recv_idle_pct       = 31;
  int holdoffs_requested  = 0;
  int holdoffs_served     = 0;
  int hold_left           = 0;
  int failures            = 0;
  int idle_cycles         = 0;

  signed_decimal_formatter_unit #(
    .DIGIT_LIMIT(DIGIT_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd      (cmd),
    .txt_valid(txt_valid),
    .txt_stall(txt_stall),
    .txt      (txt)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Fills rendered_text with the decimal text of raw, returns its character count.
  function automatic int render_decimal(input logic [63:0] raw);
    logic [63:0] mag;
    logic [7:0]  rev [0:21];
    int          n;
    int          i;
    mag = raw[63] ? 64'd0 - raw : raw;
    for (n = 0; n == 0 || (mag != 64'd0 && n < DIGIT_LIMIT); n++) begin
      rev[n] = ASCII_ZERO + 8'(mag % 64'd10);
      mag = mag / 64'd10;
    end
    if (raw[63]) begin
      rev[n] = ASCII_MINUS;
      n++;
    end
    for (i = 0; i < n; i++) begin
      rendered_text[i] = rev[n - 1 - i];
    end
    return n;
  endfunction

  function automatic void predict_text(input sdf_cmd_t req);
    sdf_txt_t r;
    int       n;
    int       i;
    if (req.capacity == '0) begin
      r = '{text_byte: ASCII_NUL, byte_written: 1'b0, length: '0, last: 1'b1};
      expected_text.push_back(r);
      return;
    end
    n = render_decimal(req.value);
    if (n + 1 > int'(req.capacity)) begin
      r = '{text_byte: ASCII_NUL, byte_written: 1'b1, length: '0, last: 1'b1};
      expected_text.push_back(r);
      return;
    end
    for (i = 0; i < n; i++) begin
      r = '{text_byte: rendered_text[i], byte_written: 1'b1, length: LEN_W'(n), last: 1'b0};
      expected_text.push_back(r);
    end
    r = '{text_byte: ASCII_NUL, byte_written: 1'b1, length: LEN_W'(n), last: 1'b1};
    expected_text.push_back(r);
  endfunction

  function automatic void add_request(input logic [63:0] v, input logic [7:0] c);
    sdf_cmd_t req;
    req.value    = v;
    req.capacity = c;
    pending_requests.push_back(req);
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: ;
      1: v = 64'($urandom_range(999));
      2: begin
        p = 64'd1;
        k = $urandom_range(18);
        repeat (k) p = p * 64'd10;
        v = p - 64'($urandom_range(1));
      end
      3: begin
        case ($urandom_range(4))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7fff_ffff_ffff_ffff;
          2: v = 64'd0;
          3: v = '1;
          default: v = 64'd1;
        endcase
      end
      default: v = v >> $urandom_range(63);
    endcase
    if (!v[63] && $urandom_range(1) == 1) begin
      v = 64'd0 - v;
    end
    return v;
  endfunction

  function automatic void queue_random(input int count);
    logic [63:0] v;
    logic [7:0]  c;
    int          n;
    repeat (count) begin
      v = random_value();
      n = render_decimal(v);
      case ($urandom_range(9))
        0: c = 8'd0;
        1: c = 8'(n);
        2, 3, 4: c = 8'(n + 1);
        5: c = 8'($urandom_range(255));
        6: c = 8'($urandom_range(n, 1));
        default: c = 8'($urandom_range(40, n + 1));
      endcase
      add_request(v, c);
    end
  endfunction

  task automatic wait_sent();
    while (pending_requests.size() != 0) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || cmd_valid || expected_text.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (cmd_valid) predict_text(cmd);
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd       <= pending_requests.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // text monitor
  always @(posedge clk) begin
    if (rst) begin
      txt_stall <= 1'b0;
    end else begin
      if (txt_valid && !txt_stall) begin
        if (expected_text.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected text: byte %h written %b length %0d last %b",
                     txt.text_byte, txt.byte_written, txt.length, txt.last);
          end
        end else begin
          want = expected_text.pop_front();
          if (txt.text_byte !== want.text_byte || txt.byte_written !== want.byte_written ||
              txt.length !== want.length || txt.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
              $write("mismatch: expected byte %h written %b length %0d last %b, ",
                     want.text_byte, want.byte_written, want.length, want.last);
              $display("got byte %h written %b length %0d last %b",
                       txt.text_byte, txt.byte_written, txt.length, txt.last);
            end
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        txt_stall <= 1'b1;
      end else if (holdoffs_served != holdoffs_requested) begin
        holdoffs_served <= holdoffs_served + 1;
        hold_left       <= HOLDOFF_CYCLES;
        txt_stall       <= 1'b1;
      end else begin
        txt_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (txt_valid && !txt_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_request(64'd0, 8'd1);
    add_request(64'd0, 8'd0);
    add_request(64'd0, 8'd2);
    add_request(64'd1, 8'd2);
    add_request('1, 8'd3);
    add_request('1, 8'd2);
    add_request(64'h7fff_ffff_ffff_ffff, 8'd20);
    add_request(64'h7fff_ffff_ffff_ffff, 8'd19);
    add_request(64'h7fff_ffff_ffff_ffff, 8'd255);
    add_request(64'h8000_0000_0000_0000, 8'd21);
    add_request(64'h8000_0000_0000_0000, 8'd20);
    add_request(64'h8000_0000_0000_0000, 8'd255);
    add_request(64'h8000_0000_0000_0000, 8'd0);
    add_request(64'd1_000_000_000_000_000_000, 8'd20);
    add_request(64'd0 - 64'd1_000_000_000_000_000_000, 8'd21);
    add_request(64'd999_999_999_999_999_999, 8'd19);
    add_request(64'd123, 8'd0);
    add_request(64'd0 - 64'd5, 8'd0);
    add_request(64'd42, 8'd255);
    add_request(64'd0 - 64'd9, 8'd3);
    add_request(64'd0 - 64'd9, 8'd2);
    add_request(64'd9, 8'd1);
    add_request(64'd10, 8'd3);
    add_request(64'd0 - 64'd100, 8'd5);
    add_request(64'h5555_5555_5555_5555, 8'haa);
    wait_sent();

    queue_random(150);
    wait_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(120);
    wait_drained();

    // receiver holds off while requests keep coming, so the input backs up
    holdoffs_requested = holdoffs_requested + 1;
    queue_random(24);
    wait_sent();
    send_idle_pct = 31;
    recv_idle_pct = 31;
    wait_drained();

    queue_random(170);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (failures == 0 && expected_text.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
